// File: hw/rtl/ttlc_pkg.sv
// Shared constants and types for the TTL keyed cache.
package ttlc_pkg;

  localparam int DEPTH_DEF        = 256;
  localparam int HANDLE_WIDTH_DEF = 32;
  localparam int KEY_W            = 256;
  localparam int TIME_W           = 64;
  localparam logic [31:0] TTL_RESET = 32'd1800000;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } ttlc_tag_t;

endpackage

// File: hw/rtl/ttlc_cell.sv
// One slot of the rotating entry ring.
module ttlc_cell import ttlc_pkg::*; #(
  parameter int HW = HANDLE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  ttlc_tag_t     d_tag,
  input  logic [HW-1:0] d_handle,
  output ttlc_tag_t     q_tag,
  output logic [HW-1:0] q_handle
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_tag.valid <= 1'b0;
    end else if (shift) begin
      q_tag.valid <= d_tag.valid;
    end
    if (shift) begin
      q_tag.key   <= d_tag.key;
      q_tag.stamp <= d_tag.stamp;
      q_handle    <= d_handle;
    end
  end

endmodule

// File: hw/rtl/ttlc_seq.sv
// Scan sequencer: examines the ring head each cycle of a scan pass and builds the result word.
module ttlc_seq import ttlc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int HW    = HANDLE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [31:0]   ttl_ms,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [63:0]   now_ms,
  input  logic [63:0]   key_word0,
  input  logic [63:0]   key_word1,
  input  logic [63:0]   key_word2,
  input  logic [63:0]   key_word3,
  input  logic [31:0]   entry_handle,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          hit,
  output logic [31:0]   found_handle,
  output logic [7:0]    slot_used,
  output logic          displaced_valid,
  output logic [31:0]   displaced_handle,
  output logic          shift,
  input  ttlc_tag_t     head_tag,
  input  logic [HW-1:0] head_handle,
  output ttlc_tag_t     fb_tag,
  output logic [HW-1:0] fb_handle
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  typedef enum logic [2:0] {IDLE, LOOK, FIND, WRITE, DONE} state_t;

  state_t         state;
  logic [31:0]    ttl;
  logic [IW-1:0]  cnt;
  logic           flag;
  logic [IW-1:0]  tgt;
  logic [IW-1:0]  oidx;
  logic [63:0]    oldest;
  logic [63:0]    now;
  logic [KEY_W-1:0] key;
  logic [HW-1:0]  hnd;
  logic           r_hit;
  logic [31:0]    r_fh;
  logic [IW-1:0]  r_slot;
  logic           r_dv;
  logic [31:0]    r_dh;

  logic [63:0]    age;
  logic           expired;
  logic           match;
  logic [HW+31:0] head_ext;
  logic [HW+31:0] in_ext;
  logic [IW+7:0]  slot_ext;

  assign age      = now - head_tag.stamp;
  assign expired  = age > {32'd0, ttl};
  assign match    = head_tag.key == key;
  assign head_ext = {32'd0, head_handle};
  assign in_ext   = {{HW{1'b0}}, entry_handle};
  assign slot_ext = {8'd0, r_slot};
  assign in_ready = state == IDLE;
  assign shift    = state == LOOK || state == FIND || state == WRITE;

  always_comb begin
    fb_tag    = head_tag;
    fb_handle = head_handle;
    case (state)
      LOOK: begin
        if (!flag && head_tag.valid && expired) fb_tag.valid = 1'b0;
      end
      WRITE: begin
        if (cnt == tgt) begin
          fb_tag.valid = 1'b1;
          fb_tag.key   = key;
          fb_tag.stamp = now;
          fb_handle    = hnd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ttl       <= TTL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) ttl <= ttl_ms;
      if (out_valid && out_ready && state != DONE) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) begin
            now    <= now_ms;
            key    <= {key_word3, key_word2, key_word1, key_word0};
            hnd    <= in_ext[HW-1:0];
            cnt    <= '0;
            flag   <= 1'b0;
            r_hit  <= 1'b0;
            r_fh   <= '0;
            r_slot <= '0;
            r_dv   <= 1'b0;
            r_dh   <= '0;
            state  <= kind ? FIND : LOOK;
          end
        end
        LOOK: begin
          if (!flag && head_tag.valid && !expired && match) begin
            flag   <= 1'b1;
            r_hit  <= 1'b1;
            r_fh   <= head_ext[31:0];
            r_slot <= cnt;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST) state <= DONE;
        end
        FIND: begin
          if (!flag && (!head_tag.valid || expired)) begin
            flag <= 1'b1;
            tgt  <= cnt;
          end
          if (cnt == '0 || head_tag.stamp < oldest) begin
            oldest <= head_tag.stamp;
            oidx   <= cnt;
          end
          if (cnt == LAST) begin
            cnt <= '0;
            if (!flag && !(!head_tag.valid || expired)) begin
              tgt <= (head_tag.stamp < oldest) ? cnt : oidx;
            end
            state <= WRITE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        WRITE: begin
          if (cnt == tgt) begin
            r_dv   <= head_tag.valid;
            r_dh   <= head_tag.valid ? head_ext[31:0] : 32'd0;
            r_slot <= cnt;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST) state <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            hit              <= r_hit;
            found_handle     <= r_fh;
            slot_used        <= slot_ext[7:0];
            displaced_valid  <= r_dv;
            displaced_handle <= r_dh;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ttl_keyed_cache_oldest_evict.sv
// Top level: TTL keyed cache built as a rotating ring of entry cells.
//   channel  dir  handshake            word
//   in       in   in_valid/in_ready    kind, now_ms, key_word0..3, entry_handle
//   out      out  out_valid/out_ready  hit, found_handle, slot_used, displaced_*
//   cfg      in   cfg_we               ttl_ms
// While a pass runs, entries rotate one cell per cycle past the head, where the sequencer checks them.
// A lookup makes one pass round the ring; an insert makes a find pass and then a write pass.
// Reset clears valid bits and control at once; no clearing pass.
// A finished word waits in the output register while the next item is accepted.
module ttl_keyed_cache_oldest_evict import ttlc_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] ttl_ms,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] now_ms,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [63:0] key_word3,
  input  logic [31:0] entry_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] found_handle,
  output logic [7:0]  slot_used,
  output logic        displaced_valid,
  output logic [31:0] displaced_handle
);

  ttlc_tag_t                tag_q [DEPTH];
  logic [HANDLE_WIDTH-1:0]  hnd_q [DEPTH];
  ttlc_tag_t                fb_tag;
  logic [HANDLE_WIDTH-1:0]  fb_handle;
  logic                     shift;

  for (genvar i = 0; i < DEPTH; i++) begin : g_ring
    if (i == DEPTH - 1) begin : g_tail
      ttlc_cell #(.HW(HANDLE_WIDTH)) u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .d_tag(fb_tag), .d_handle(fb_handle),
        .q_tag(tag_q[i]), .q_handle(hnd_q[i])
      );
    end else begin : g_body
      ttlc_cell #(.HW(HANDLE_WIDTH)) u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .d_tag(tag_q[i+1]), .d_handle(hnd_q[i+1]),
        .q_tag(tag_q[i]), .q_handle(hnd_q[i])
      );
    end
  end

  ttlc_seq #(.DEPTH(DEPTH), .HW(HANDLE_WIDTH)) u_seq (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .ttl_ms(ttl_ms),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .now_ms(now_ms),
    .key_word0(key_word0), .key_word1(key_word1),
    .key_word2(key_word2), .key_word3(key_word3),
    .entry_handle(entry_handle),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .found_handle(found_handle), .slot_used(slot_used),
    .displaced_valid(displaced_valid), .displaced_handle(displaced_handle),
    .shift(shift),
    .head_tag(tag_q[0]), .head_handle(hnd_q[0]),
    .fb_tag(fb_tag), .fb_handle(fb_handle)
  );

endmodule
